>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the PID channel checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PID_AW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid_aw: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define PID_AW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid_aw: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define PID_AW_ASSERT_NXT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pid_aw: reset check failed");

`endif

>>> design/pid_aw_pkg.sv
// ----------------------------------------------------------------------------
// pid_aw_pkg
// Types, register codes and constants of the PID anti-windup channel.
// ----------------------------------------------------------------------------
package pid_aw_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int SUM_WIDTH_DEF = 32;

    localparam int DATA_W    = 16;   // Q8.8 samples, gains and drive
    localparam int LIMIT_W   = 15;   // PWM limit magnitude
    localparam int ERR_W     = 17;   // setpoint minus measurement
    localparam int CFG_IDX_W = 3;

    // Measurement jump filter threshold, in whole units
    localparam int JUMP_STEPS = 10;

    // Drive forced while the tension alarm is raised
    localparam logic signed [DATA_W-1:0] ALARM_DRIVE = -16'sd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_PWM_LIMIT    = 3'd3,
        REG_MANUAL_MODE  = 3'd4,
        REG_MANUAL_DRIVE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [DATA_W-1:0]  prop_gain;
        logic [DATA_W-1:0]  integ_gain;
        logic [DATA_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] pwm_limit;
        logic               manual_mode;
        logic [DATA_W-1:0]  manual_drive;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] setpoint;
        logic [DATA_W-1:0] measurement;
        logic              tension_alarm;
    } sample_t;

    typedef struct packed {
        logic [DATA_W-1:0] motor_drive;
        logic              saturated;
    } result_t;

endpackage

>>> design/pid_aw_law.sv
// ----------------------------------------------------------------------------
// pid_aw_law
// Controller state and one-pass PID law with jump filter and anti-windup.
// ----------------------------------------------------------------------------
module pid_aw_law #(
    parameter int FRAC_BITS = pid_aw_pkg::FRAC_BITS_DEF,
    parameter int SUM_WIDTH = pid_aw_pkg::SUM_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  pid_aw_pkg::sample_t sample,
    input  pid_aw_pkg::cfg_t    cfg,
    output pid_aw_pkg::result_t result
);

    localparam int SHIFT  = 2 * FRAC_BITS;
    localparam int LIM_W  = pid_aw_pkg::LIMIT_W + SHIFT + 1;
    localparam int UW_SUM = SUM_WIDTH + 18;
    localparam int UW     = (UW_SUM > LIM_W + 1) ? UW_SUM : LIM_W + 1;
    localparam int PI_W   = SUM_WIDTH + pid_aw_pkg::DATA_W;

    localparam logic signed [17:0] JUMP_LIMIT = 18'(pid_aw_pkg::JUMP_STEPS << FRAC_BITS);
    localparam logic signed [UW-1:0] ROUND_BIAS = UW'((64'd1 << SHIFT) - 64'd1);
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [15:0]          kept_meas_reg, kept_meas_next;
    logic signed [16:0]          prev_err_reg, err;
    logic signed [SUM_WIDTH-1:0] integ_reg, integ_next, integ_base, integ_sat;
    logic                        sat_reg, sat_next;

    logic signed [15:0]          setpoint, measurement;
    logic signed [17:0]          jump, err_delta;
    logic                        same_sign;
    logic signed [SUM_WIDTH:0]   integ_wide;
    logic signed [32:0]          p_prod;
    logic signed [33:0]          d_prod;
    logic signed [PI_W-1:0]      i_prod;
    logic signed [UW-1:0]        u_raw, u_clamp, u_bias, lim_pos, lim_neg;
    logic signed [15:0]          drive_ctl;

    assign setpoint    = $signed(sample.setpoint);
    assign measurement = $signed(sample.measurement);

    // Jump filter: keep the new measurement only when close to the last kept one
    always_comb begin
        jump = 18'(measurement) - 18'(kept_meas_reg);
        if ((jump < JUMP_LIMIT) && (jump > -JUMP_LIMIT)) begin
            kept_meas_next = measurement;
        end else begin
            kept_meas_next = kept_meas_reg;
        end
    end

    assign err       = 17'(setpoint) - 17'(kept_meas_next);
    assign err_delta = 18'(err) - 18'(prev_err_reg);

    // Anti-windup: clear unless the error keeps a strict sign, freeze while saturated
    always_comb begin
        same_sign  = ((err > 17'sd0) && (prev_err_reg > 17'sd0)) ||
                     ((err < 17'sd0) && (prev_err_reg < 17'sd0));
        integ_base = same_sign ? integ_reg : '0;
        integ_wide = (SUM_WIDTH+1)'(integ_base) + (SUM_WIDTH+1)'(err);
        if (integ_wide[SUM_WIDTH] != integ_wide[SUM_WIDTH-1]) begin
            integ_sat = integ_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            integ_sat = integ_wide[SUM_WIDTH-1:0];
        end
        integ_next = sat_reg ? integ_base : integ_sat;
    end

    always_comb begin
        p_prod = 33'($signed(cfg.prop_gain)) * 33'(err);
        d_prod = 34'($signed(cfg.deriv_gain)) * 34'(err_delta);
        i_prod = PI_W'($signed(cfg.integ_gain)) * PI_W'(integ_next);
        u_raw  = UW'(p_prod) + UW'(d_prod) + UW'(i_prod);
    end

    // Clamp to the PWM limit, then truncate toward zero
    always_comb begin
        lim_pos = $signed({{(UW-pid_aw_pkg::LIMIT_W){1'b0}}, cfg.pwm_limit}) <<< SHIFT;
        lim_neg = -lim_pos;
        if (u_raw > lim_pos) begin
            u_clamp  = lim_pos;
            sat_next = 1'b1;
        end else if (u_raw < lim_neg) begin
            u_clamp  = lim_neg;
            sat_next = 1'b1;
        end else begin
            u_clamp  = u_raw;
            sat_next = 1'b0;
        end
        u_bias    = (u_clamp < 0) ? (u_clamp + ROUND_BIAS) : u_clamp;
        drive_ctl = u_bias[SHIFT +: 16];
    end

    always_comb begin
        if (cfg.manual_mode) begin
            result.motor_drive = cfg.manual_drive;
        end else if (sample.tension_alarm) begin
            result.motor_drive = pid_aw_pkg::ALARM_DRIVE;
        end else begin
            result.motor_drive = drive_ctl;
        end
        result.saturated = sat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_meas_reg <= '0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            sat_reg       <= 1'b0;
        end else if (advance) begin
            kept_meas_reg <= kept_meas_next;
            prev_err_reg  <= err;
            integ_reg     <= integ_next;
            sat_reg       <= sat_next;
        end
    end

endmodule

>>> design/pid_antiwindup_channel_unit.sv
// ----------------------------------------------------------------------------
// pid_antiwindup_channel_unit
// One PID control channel with measurement jump filter and anti-windup.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one controller tick per transfer: setpoint and measurement
//   in s_tdata, the tension alarm in s_tuser. m_* returns exactly one result
//   per tick: motor drive in m_tdata, the saturation flag in m_tuser.
//   cfg_* writes the gain, limit and manual registers; write them only while
//   no tick is in flight. cfg_ready is always high.
//   Path: the input register, then the result register, from the input
//   transfer to m_tvalid. Throughput: one tick per cycle while m_tready
//   stays high; the controller state (kept measurement, previous error,
//   integral, saturation flag) updates in the same pass that fills the
//   result register, so the next tick sees it at once.
//   Reset (aresetn low, synchronous): clears the pipeline and the controller
//   state, gains and limit to zero, and selects manual mode with drive zero.
//   When the receiver stalls, the result holds in its register; one more
//   tick waits in the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module pid_antiwindup_channel_unit #(
    parameter int FRAC_BITS = pid_aw_pkg::FRAC_BITS_DEF,
    parameter int SUM_WIDTH = pid_aw_pkg::SUM_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] setpoint, [31:16] measurement
    input  logic        s_tuser,    // [0] tension_alarm

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] motor_drive
    output logic        m_tuser,    // [0] saturated

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    pid_aw_pkg::cfg_t    cfg_reg, cfg_next;
    pid_aw_pkg::sample_t sample_reg;
    pid_aw_pkg::result_t result_reg, law_result;
    logic                in_valid_reg, out_valid_reg;
    logic                advance;

    // Move the held tick into the result register when that slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes drop
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (pid_aw_pkg::cfg_reg_t'(cfg_index))
                pid_aw_pkg::REG_PROP_GAIN:    cfg_next.prop_gain    = cfg_data;
                pid_aw_pkg::REG_INTEG_GAIN:   cfg_next.integ_gain   = cfg_data;
                pid_aw_pkg::REG_DERIV_GAIN:   cfg_next.deriv_gain   = cfg_data;
                pid_aw_pkg::REG_PWM_LIMIT:    cfg_next.pwm_limit    = cfg_data[14:0];
                pid_aw_pkg::REG_MANUAL_MODE:  cfg_next.manual_mode  = cfg_data[0];
                pid_aw_pkg::REG_MANUAL_DRIVE: cfg_next.manual_drive = cfg_data;
                default: ;
            endcase
        end
    end

    // Reset to zero gains and limit, manual mode with zero drive
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{prop_gain:    '0,
                         integ_gain:   '0,
                         deriv_gain:   '0,
                         pwm_limit:    '0,
                         manual_mode:  1'b1,
                         manual_drive: '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register: hold the tick until the law consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg.setpoint      <= s_tdata[15:0];
            sample_reg.measurement   <= s_tdata[31:16];
            sample_reg.tension_alarm <= s_tuser;
        end
    end

    pid_aw_law #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_law (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .sample  (sample_reg),
        .cfg     (cfg_reg),
        .result  (law_result)
    );

    // Result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= law_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg.motor_drive;
    assign m_tuser  = result_reg.saturated;

endmodule

>>> design/pid_aw_checker.sv
// ----------------------------------------------------------------------------
// pid_aw_checker
// Port-level checks of the PID channel handshake and pipeline timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_aw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // Reset empties the pipeline and opens the input
    `PID_AW_ASSERT_NXT_RST(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)

    // A stalled result holds its value
    `PID_AW_ASSERT_NXT(a_hold_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // The input only closes when the output side is stalled
    `PID_AW_ASSERT_IMP(a_ready_backpressure, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // An accepted tick reaches the output through the input and result registers when drained
    `PID_AW_ASSERT_NXT(a_latency, aclk, aresetn, (s_tvalid && s_tready) ##1 m_tready, m_tvalid)

endmodule

bind pid_antiwindup_channel_unit pid_aw_checker u_pid_aw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/pid_antiwindup_channel_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_antiwindup_channel_unit_tb
// Self-checking bench for one PID channel with jump filter and anti-windup.
// A queue-fed driver sends controller ticks, and a cycle-level controller
// model predicts each drive and saturation flag. A monitor matches every
// result transfer against the oldest prediction. Register settings change
// only between phases. The phases are directed corner ticks, random walks
// at several gain and limit settings, and two runs of steady full-scale
// error that build the integral in each direction.
// ----------------------------------------------------------------------------
module pid_antiwindup_channel_unit_tb;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int IDLE_PCT        = 24;    // chance of a bubble on either side
    localparam int RX_HOLD_CYCLES  = 64;    // long receiver stall
    localparam int RX_HOLD_FIRST   = 170;   // tick count of the first long stall
    localparam int RX_HOLD_STEP    = 200;
    localparam int CALM_FROM       = 230;   // window with no bubbles at all
    localparam int CALM_TO         = 310;
    localparam int RANDOM_PHASES   = 5;
    localparam int TICKS_PER_PHASE = 90;
    localparam int SOAK_TICKS      = 10;    // full-scale errors of one sign
    localparam int RAMP_STEP       = 2048;  // below the jump threshold
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;

    localparam int FRAC   = pid_aw_pkg::FRAC_BITS_DEF;
    localparam int SUM_W  = pid_aw_pkg::SUM_WIDTH_DEF;
    localparam int IDX_W  = pid_aw_pkg::CFG_IDX_W;
    localparam int DAT_W  = pid_aw_pkg::DATA_W;
    localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    // Register indexes past the last real register; writes there do nothing.
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [DAT_W-1:0] data;
    } reg_write_t;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // [15:0] setpoint, [31:16] measurement
    logic        s_tuser   = 1'b0;  // [0] tension_alarm
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [15:0] motor_drive
    logic        m_tuser;           // [0] saturated
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    pid_antiwindup_channel_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Invert the clock every half period.
    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    pid_aw_pkg::sample_t tick_q[$];          // ticks waiting for the driver
    reg_write_t          reg_write_q[$];     // register writes waiting for the driver
    pid_aw_pkg::result_t drive_expect_q[$];  // predicted results, oldest first
    pid_aw_pkg::sample_t next_tick;
    reg_write_t          next_write;
    pid_aw_pkg::result_t oldest_drive;

    int in_count       = 0;
    int checked_count  = 0;
    int cfg_writes     = 0;
    int mismatch_count = 0;
    int filter_rejects = 0;
    int sat_count      = 0;
    int stall_cycles   = 0;
    int rx_hold_left   = 0;
    int rx_hold_at     = RX_HOLD_FIRST;

    wire calm = (in_count >= CALM_FROM) && (in_count < CALM_TO);

    // Controller model: register copies at their reset values ...
    logic signed [DAT_W-1:0]              kp         = '0;
    logic signed [DAT_W-1:0]              ki         = '0;
    logic signed [DAT_W-1:0]              kd         = '0;
    logic        [pid_aw_pkg::LIMIT_W-1:0] pwm_lim   = '0;
    logic                                 manual_on  = 1'b1;
    logic signed [DAT_W-1:0]              manual_pwm = '0;
    // ... and the loop state, cleared by reset.
    logic signed [DAT_W-1:0]              kept_meas  = '0;
    logic signed [pid_aw_pkg::ERR_W-1:0]  prev_err   = '0;
    logic signed [SUM_W-1:0]              integ_acc  = '0;
    logic                                 sat_flag   = 1'b0;

    // ------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------
    task automatic apply_reg_write(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] d);
        case (idx)
            pid_aw_pkg::REG_PROP_GAIN:    kp         = d;
            pid_aw_pkg::REG_INTEG_GAIN:   ki         = d;
            pid_aw_pkg::REG_DERIV_GAIN:   kd         = d;
            pid_aw_pkg::REG_PWM_LIMIT:    pwm_lim    = d[pid_aw_pkg::LIMIT_W-1:0];
            pid_aw_pkg::REG_MANUAL_MODE:  manual_on  = d[0];
            pid_aw_pkg::REG_MANUAL_DRIVE: manual_pwm = d;
            default: ;        // spare index: drop the write
        endcase
    endtask

    // Advance the loop by one tick and return the drive it produces.
    function automatic pid_aw_pkg::result_t run_controller(pid_aw_pkg::sample_t t);
        longint              sp, meas, jump, err, acc, u, lim, drv;
        pid_aw_pkg::result_t r;
        sp   = longint'($signed(t.setpoint));
        meas = longint'($signed(t.measurement));

        // Jump filter: keep the sample only if it moved less than the threshold.
        jump = meas - longint'(kept_meas);
        if (jump < 0)
            jump = -jump;
        if (jump < (longint'(pid_aw_pkg::JUMP_STEPS) << FRAC))
            kept_meas = t.measurement;
        else
            filter_rejects++;

        err = sp - longint'(kept_meas);

        // Clear the integral unless the error kept a strict sign.
        if (!((err > 0 && prev_err > 0) || (err < 0 && prev_err < 0)))
            integ_acc = '0;
        // Hold the integral while the last output was clamped.
        if (!sat_flag) begin
            acc = longint'(integ_acc) + err;
            if (acc > SUM_MAX)
                acc = SUM_MAX;
            else if (acc < SUM_MIN)
                acc = SUM_MIN;
            integ_acc = acc;
        end

        u = longint'(kp) * err
          + longint'(kd) * (err - longint'(prev_err))
          + longint'(ki) * longint'(integ_acc);

        lim = longint'(pwm_lim) << (2 * FRAC);
        if (u > lim) begin
            u        = lim;
            sat_flag = 1'b1;
        end else if (u < -lim) begin
            u        = -lim;
            sat_flag = 1'b1;
        end else begin
            sat_flag = 1'b0;
        end

        // Signed division truncates toward zero.
        drv      = u / (longint'(1) << (2 * FRAC));
        prev_err = err;

        if (manual_on)
            drv = longint'(manual_pwm);
        else if (t.tension_alarm)
            drv = longint'(pid_aw_pkg::ALARM_DRIVE);

        r.motor_drive = drv[DAT_W-1:0];
        r.saturated   = sat_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: all DUT inputs change by nonblocking assignment at posedge.
    // ------------------------------------------------------------------
    // Tick driver: advance only after the current transfer completes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tick_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                next_tick = tick_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_tick.measurement, next_tick.setpoint};
                s_tuser  <= next_tick.tension_alarm;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Register write driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else if (!cfg_valid || cfg_ready) begin
            if (reg_write_q.size() != 0) begin
                next_write = reg_write_q.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= next_write.index;
                cfg_data  <= next_write.data;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random bubbles, plus a long hold-off every few hundred
    // ticks so the result and input registers fill and s_tready drops.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else if (in_count >= rx_hold_at) begin
            rx_hold_left <= RX_HOLD_CYCLES;
            rx_hold_at   <= rx_hold_at + RX_HOLD_STEP;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Input side: track register writes and predict each accepted tick.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_reg_write(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (s_tvalid && s_tready) begin
                drive_expect_q.push_back(run_controller(pid_aw_pkg::sample_t'{
                    setpoint:      s_tdata[15:0],
                    measurement:   s_tdata[31:16],
                    tension_alarm: s_tuser}));
                if (drive_expect_q[$].saturated)
                    sat_count++;
                in_count++;
            end
        end
    end

    // Result side: compare each transfer with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_expect_q.size() == 0) begin
                report_mismatch($sformatf("result with no tick pending: drive %0d sat %0b",
                                          $signed(m_tdata), m_tuser));
            end else begin
                oldest_drive = drive_expect_q.pop_front();
                if (m_tdata !== oldest_drive.motor_drive)
                    report_mismatch($sformatf("result %0d: motor_drive %0d, want %0d",
                                              checked_count, $signed(m_tdata),
                                              $signed(oldest_drive.motor_drive)));
                if (m_tuser !== oldest_drive.saturated)
                    report_mismatch($sformatf("result %0d: saturated %0b, want %0b",
                                              checked_count, m_tuser,
                                              oldest_drive.saturated));
                checked_count++;
            end
        end
    end

    // Count cycles with no transfer on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog: end the run if traffic stops for too long.
    initial begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, drive_expect_q.size());
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; the sequencer syncs on negedge so queue and handshake
    // state are settled when it looks at them.
    // ------------------------------------------------------------------
    task automatic push_tick(logic [15:0] sp, logic [15:0] meas, logic alarm);
        tick_q.push_back(pid_aw_pkg::sample_t'{setpoint: sp, measurement: meas,
                                               tension_alarm: alarm});
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] d);
        reg_write_q.push_back(reg_write_t'{index: idx, data: d});
    endtask

    // Hold until nothing is queued, offered or in flight.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (tick_q.size() != 0 || s_tvalid || reg_write_q.size() != 0 || cfg_valid
               || drive_expect_q.size() != 0);
    endtask

    task automatic set_controller(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                                  logic [15:0] lim, logic [15:0] mode, logic [15:0] man);
        write_reg(pid_aw_pkg::REG_PROP_GAIN, p);
        write_reg(pid_aw_pkg::REG_INTEG_GAIN, i);
        write_reg(pid_aw_pkg::REG_DERIV_GAIN, d);
        write_reg(pid_aw_pkg::REG_PWM_LIMIT, lim);
        write_reg(pid_aw_pkg::REG_MANUAL_MODE, mode);
        write_reg(pid_aw_pkg::REG_MANUAL_DRIVE, man);
        wait_idle();
    endtask

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Walk the kept measurement to a target in steps the filter accepts.
    task automatic ramp_measurement(int target);
        int m;
        m = kept_meas;
        while (m != target) begin
            if (target > m)
                m = (target - m > RAMP_STEP) ? m + RAMP_STEP : target;
            else
                m = (m - target > RAMP_STEP) ? m - RAMP_STEP : target;
            push_tick(16'h0000, m[15:0], 1'b0);
        end
    endtask

    // Mostly a smooth measurement walk with a slowly drifting setpoint
    // offset, so the integral builds over runs of same-sign error. Mix in
    // wild measurements that the filter should drop and full-range setpoints.
    task automatic run_random(int n);
        int walk, bias, sp, meas;
        walk = kept_meas;
        bias = 0;
        repeat (n) begin
            if ($urandom_range(7) == 0)
                bias = int'($urandom_range(8191)) - 4096;
            if ($urandom_range(99) < 15) begin
                meas = int'($urandom_range(65535)) - 32768;
            end else begin
                walk = clamp16(walk + int'($urandom_range(4000)) - 2000);
                meas = walk;
            end
            if ($urandom_range(99) < 10)
                sp = int'($urandom_range(65535)) - 32768;
            else
                sp = clamp16(walk + bias);
            push_tick(sp[15:0], meas[15:0], $urandom_range(99) < 10);
        end
    endtask

    // Build the integral over a run of full-scale error with all gains at
    // zero, then expose the held value through a tiny integral gain.
    task automatic soak_integral(bit upward);
        logic [15:0] sp_end, meas_end;
        sp_end   = upward ? 16'h7FFF : 16'h8000;
        meas_end = upward ? 16'h8000 : 16'h7FFF;
        set_controller(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
        ramp_measurement($signed(meas_end));
        repeat (SOAK_TICKS)
            push_tick(sp_end, meas_end, 1'b0);
        wait_idle();
        write_reg(pid_aw_pkg::REG_INTEG_GAIN, 16'h0001);
        wait_idle();
        repeat (4)
            push_tick(sp_end, meas_end, 1'b0);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset values: manual mode with zero drive, alarm ignored.
        push_tick(16'h0400, 16'h0100, 1'b0);
        push_tick(16'hFC00, 16'h0000, 1'b1);
        wait_idle();

        // Directed: unit proportional gain, small I and D, limit of 100.
        set_controller(16'h0100, 16'h0020, 16'h0040, 16'h0064, 16'hFFFE, 16'h1234);
        write_reg(CFG_IDX_SPARE_A, 16'hFFFF);
        write_reg(CFG_IDX_SPARE_B, 16'h0001);
        wait_idle();
        push_tick(16'h0000, 16'h0000, 1'b0);   // zero error clears the integral
        push_tick(16'h0500, 16'h0000, 1'b0);   // positive error starts it
        push_tick(16'h0500, 16'h0200, 1'b0);   // same sign, keep adding
        push_tick(16'h0500, 16'h0C00, 1'b0);   // jump of exactly ten: drop it
        push_tick(16'h0500, 16'h0BFF, 1'b0);   // just under ten: keep, sign flips
        push_tick(16'h7FFF, 16'h0BFF, 1'b0);   // clamp high
        push_tick(16'h7FFF, 16'h0BFF, 1'b0);   // clamped: integral holds
        push_tick(16'h8000, 16'h0BFF, 1'b0);   // clamp low
        push_tick(16'h0000, 16'h7FFF, 1'b0);   // extreme measurements, both dropped
        push_tick(16'h0000, 16'h8000, 1'b0);
        push_tick(16'h0100, 16'h0BFF, 1'b1);   // alarm forces reverse drive
        push_tick(16'h0000, 16'h0BFF, 1'b1);
        wait_idle();

        // Manual mode at both drive extremes; the alarm must not win.
        set_controller(16'h0100, 16'h0020, 16'h0040, 16'h0064, 16'h0001, 16'h7FFF);
        push_tick(16'h0300, 16'h0BFF, 1'b1);
        push_tick(16'h0300, 16'h0BFF, 1'b0);
        wait_idle();
        write_reg(pid_aw_pkg::REG_MANUAL_DRIVE, 16'h8000);
        wait_idle();
        push_tick(16'h7FFF, 16'h0BFF, 1'b0);
        wait_idle();

        // Zero limit with extreme gains: any nonzero output clamps to zero.
        set_controller(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        push_tick(16'h0200, 16'h0BFF, 1'b0);
        push_tick(16'h0BFF, 16'h0BFF, 1'b0);   // zero error after a nonzero one
        push_tick(16'h0BFF, 16'h0BFF, 1'b0);   // zero error twice: output zero
        push_tick(16'h0AFF, 16'h0BFF, 1'b0);
        wait_idle();

        // Random phases: gentle, all-max, all-min with zero limit, then random.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_controller(16'h0100, 16'h0010, 16'h0040, 16'h00C8,
                                  16'hFFFE, 16'h0000);
                1: set_controller(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                                  16'h0000, 16'h0000);
                2: set_controller(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h0000, 16'h0000);
                default: set_controller($urandom_range(65535), $urandom_range(65535),
                                        $urandom_range(65535), $urandom_range(65535),
                                        $urandom_range(65535), $urandom_range(65535));
            endcase
            run_random(TICKS_PER_PHASE);
            wait_idle();
        end

        // Steady full-scale error in both directions.
        soak_integral(1'b1);
        soak_integral(1'b0);

        // Let any stray result surface before the verdict.
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d ticks and %0d register writes: directed corners, %0d random",
                 in_count, cfg_writes, RANDOM_PHASES * TICKS_PER_PHASE);
        $display("ticks, two steady-error runs; %0d results checked, %0d filter drops, %0d clamped",
                 checked_count, filter_rejects, sat_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
